// ===== sv/whdp_pkg.sv =====
// ----------------------------------------------------------------------------
// whdp_pkg: shared types and constants for the word hash digit pattern unit
// Holds the controller state type, the command and status structs between
// the controller and the datapath, and the mod-ten digit function.
// ----------------------------------------------------------------------------
package whdp_pkg;

  localparam int PatternLen = 64;
  localparam int MaxRun     = 64;
  localparam int RunLen     = (PatternLen > MaxRun) ? MaxRun :
                              ((PatternLen < 1) ? 1 : PatternLen);

  localparam int IdxW = 6;
  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(RunLen - 1);

  localparam logic [31:0] HASH_INIT = 32'd5381;
  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;

  localparam int InDataW  = 8;
  localparam int OutDataW = 48;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic add_char;
    logic load_word;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_last;
  } status_t;

  // x mod 10 via x mod 2 and x mod 5; 16 = 1 (mod 5) so nibbles fold
  function automatic logic [3:0] digit_of(input logic [31:0] x);
    logic [6:0] s;
    logic [4:0] t;
    logic [4:0] u;
    logic [3:0] r;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(x[4*i +: 4]);
    end
    t = 5'(s[6:4]) + 5'(s[3:0]);
    u = 5'(t[4]) + 5'(t[3:0]);
    if (u >= 5'd15) begin
      r = 4'(u - 5'd15);
    end else if (u >= 5'd10) begin
      r = 4'(u - 5'd10);
    end else if (u >= 5'd5) begin
      r = 4'(u - 5'd5);
    end else begin
      r = u[3:0];
    end
    if (r[0] == x[0]) begin
      return r;
    end else begin
      return r + 4'd5;
    end
  endfunction

endpackage

// ===== sv/whdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// whdp_ctrl: sequencing controller
// Takes characters and end words while idle, then steps the digit run one
// word at a time as the output register frees up.
// ----------------------------------------------------------------------------
module whdp_ctrl
  import whdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  input  logic    s_axis_tlast,
  output logic    s_axis_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tlast) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.out_free && status.at_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.add_char  = s_axis_tvalid && !s_axis_tlast;
        cmd.load_word = s_axis_tvalid && s_axis_tlast;
      end
      ST_RUN: begin
        cmd.emit = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/whdp_dpath.sv =====
// ----------------------------------------------------------------------------
// whdp_dpath: hash and digit datapath
// Running DJB2 hash, LCG generator, digit index and the output register.
// ----------------------------------------------------------------------------
module whdp_dpath
  import whdp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [InDataW-1:0]  char_code,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  logic [31:0]     running_hash;
  logic [31:0]     word_hash;
  logic [31:0]     gen;
  logic [IdxW-1:0] idx;
  logic [3:0]      out_digit;
  logic [IdxW-1:0] out_idx;
  logic [31:0]     out_hash;
  logic            out_last;
  logic [31:0]     hash_step;
  logic [31:0]     gen_step;

  assign hash_step = (running_hash << 5) + running_hash + 32'(char_code);
  assign gen_step  = gen * LCG_MUL + LCG_ADD;

  assign status.out_free = !m_axis_tvalid || m_axis_tready;
  assign status.at_last  = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= HASH_INIT;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.load_word) begin
        running_hash <= HASH_INIT;
      end else if (cmd.add_char && char_code != '0) begin
        running_hash <= hash_step;
      end
      if (cmd.emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      word_hash <= running_hash;
      gen       <= running_hash;
      idx       <= '0;
    end else if (cmd.emit) begin
      gen <= gen_step;
      idx <= idx + IdxW'(1);
    end
    if (cmd.emit) begin
      out_digit <= digit_of(gen);
      out_idx   <= idx;
      out_hash  <= word_hash;
      out_last  <= status.at_last;
    end
  end

  assign m_axis_tdata = {6'b0, out_hash, out_idx, out_digit};
  assign m_axis_tlast = out_last;

endmodule

// ===== sv/word_hash_digit_pattern_unit.sv =====
// ----------------------------------------------------------------------------
// word_hash_digit_pattern_unit: DJB2 word hash with LCG digit pattern
// Hashes the characters of a word and, on the end word, emits a run of
// decimal digits drawn from an LCG seeded with the hash.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         last
//  s_axis    in   tdata[7:0] char_code                            word_end
//  m_axis    out  tdata digit[3:0] digit_index[9:4] hash[41:10]   last_digit
//
//  Characters: one character per cycle while idle.
//  End word: 64-word digit run, one per cycle; input stalls until the
//  final digit is in the output register.
//  Output stall holds the run.
//  Reset: synchronous; hash back to 5381, output empty.
// ----------------------------------------------------------------------------
module word_hash_digit_pattern_unit
  import whdp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] digit, [9:4] digit_index,
                                              // [41:10] word_hash, zero above
  output logic                m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  whdp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  whdp_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .char_code     (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
